/* rtl/hazard_era_reclaimer_core_macros.svh */
// ----------------------------------------------------------------------------
// Hazard-era reclaimer assertion macros
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HAZARD_ERA_RECLAIMER_CORE_MACROS_SVH
`define HAZARD_ERA_RECLAIMER_CORE_MACROS_SVH
`ifndef SYNTH
`define HER_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("hazard era reclaimer check failed");
`define HER_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("hazard era reclaimer check failed");
`else
`define HER_ASSERT_IMP(lbl, a, b)
`define HER_ASSERT_NXT(lbl, a, b)
`endif
`endif

/* rtl/her_pkg.sv */
// ----------------------------------------------------------------------------
// Hazard-era reclaimer package
// Shared types, codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package her_pkg;

    localparam int THREADS_DEF       = 8;
    localparam int SLOTS_DEF         = 16;
    localparam int RETIRED_DEPTH_DEF = 32;
    // period divisor: 16-bit period times a 4-bit thread count
    localparam int DIV_W             = 20;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 3;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ACQUIRE = 2'd1,
        CMD_RETIRE  = 2'd2,
        CMD_END_OP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_FREED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_NULL  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREAD_COUNT   = 3'd0,
        CFG_SLOTS_IN_USE   = 3'd1,
        CFG_EPOCH_PERIOD   = 3'd2,
        CFG_EMPTY_PERIOD   = 3'd3,
        CFG_COLLECT_ENABLE = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERD,
        ST_RRD,
        ST_RCMP,
        ST_CSEL,
        ST_CWR,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  thread_id;
        logic [3:0]  slot_id;
        logic [31:0] object_handle;
        logic [63:0] birth_era;
    } t_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [63:0] era;
        logic [31:0] freed_handle;
        logic        last;
    } t_res;

endpackage
`default_nettype wire

/* rtl/her_divmod.sv */
// ----------------------------------------------------------------------------
// Hazard-era reclaimer remainder unit
// Bit-serial restoring remainder of a 64-bit count by a narrow period.
// ----------------------------------------------------------------------------
`default_nettype none
module her_divmod
    import her_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [63:0]       i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [DIV_W-1:0]       o_rem
);

    logic              r_busy;
    logic [5:0]        r_cnt;
    logic [63:0]       r_q;
    logic [DIV_W-1:0]  r_d;
    logic [DIV_W-1:0]  r_rem;
    logic              r_done;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    // shift in one dividend bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_q[63]};
        diff  = trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[62:0], 1'b0};
                r_rem <= (trial >= {1'b0, r_d}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

/* rtl/her_resv.sv */
// ----------------------------------------------------------------------------
// Hazard-era reclaimer reservation table
// Era memory by thread and slot, with valid bits that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none
module her_resv
    import her_pkg::*;
#(
    parameter int THREADS = THREADS_DEF,
    parameter int SLOTS   = SLOTS_DEF,
    localparam int TW     = (THREADS > 1) ? $clog2(THREADS) : 1,
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_we,
    input  wire logic [TW-1:0]  i_wtid,
    input  wire logic [SW-1:0]  i_wslot,
    input  wire logic [63:0]    i_wdata,
    input  wire logic           i_clr,
    input  wire logic [TW-1:0]  i_clr_tid,
    input  wire logic [4:0]     i_clr_cnt,
    input  wire logic           i_re,
    input  wire logic [TW-1:0]  i_rtid,
    input  wire logic [SW-1:0]  i_rslot,
    output logic [63:0]         o_rdata
);

    logic [63:0] mem [THREADS][SLOTS];
    logic        r_valid [THREADS][SLOTS];
    logic [63:0] r_q;
    logic        r_qv;

    // write and registered read of the era memory
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wtid][i_wslot] <= i_wdata;
        end
        if (i_re) begin
            r_q <= mem[i_rtid][i_rslot];
        end
    end

    // set on write, drop a row prefix on end of operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < THREADS; t++) begin
                for (int j = 0; j < SLOTS; j++) begin
                    r_valid[t][j] <= 1'b0;
                end
            end
            r_qv <= 1'b0;
        end else begin
            for (int t = 0; t < THREADS; t++) begin
                for (int j = 0; j < SLOTS; j++) begin
                    if (i_clr && (TW'(t) == i_clr_tid) && (j < int'(i_clr_cnt))) begin
                        r_valid[t][j] <= 1'b0;
                    end else if (i_we && (TW'(t) == i_wtid) && (SW'(j) == i_wslot)) begin
                        r_valid[t][j] <= 1'b1;
                    end
                end
            end
            if (i_re) begin
                r_qv <= r_valid[i_rtid][i_rslot];
            end
        end
    end

    // a slot never written reads as zero
    assign o_rdata = r_qv ? r_q : 64'd0;

endmodule
`default_nettype wire

/* rtl/hazard_era_reclaimer_core.sv */
// ----------------------------------------------------------------------------
// Hazard-era reclaimer core
// Sequencer for era, reservations, counters and per-thread retired stores.
// ----------------------------------------------------------------------------
// Usage: raise start with a command word on i_cmd; it is taken at an edge
// where busy is low. Results appear on o_res, each for one cycle with
// o_res_valid high; the receiver cannot stall them, and the final result
// of every command has last set. busy stays high until that final word.
// Acquire, end-op, null retire and commands from foreign threads answer
// without leaving idle; a retire with collection off passes ST_FINAL.
// Alloc runs the shared bit-serial remainder unit and answers when it is
// done; a non-null retire with collection on also runs it and, when no
// scan is due, answers through ST_FINAL.
// A reclamation scan compares each stored entry with the reservations
// (threads times slots in use, stopping at the first cover), then a
// compaction pass copies each kept entry down, and ST_FINAL closes it.
// The ST_RRD/ST_RCMP loop on the reservation memory port paces the scan.
// Configuration writes on i_cfg_we take effect at once and are made while
// idle, a rule for the user that the block does not enforce. Reset sets
// the era to one and clears counters, fill counts and reservation valid
// bits; stored entries need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hazard_era_reclaimer_core_macros.svh"
module hazard_era_reclaimer_core
    import her_pkg::*;
#(
    parameter int THREADS       = THREADS_DEF,
    parameter int SLOTS         = SLOTS_DEF,
    parameter int RETIRED_DEPTH = RETIRED_DEPTH_DEF
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire t_req                  i_cmd,
    output logic                       busy,
    output logic                       o_res_valid,
    output t_res                       o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = (RETIRED_DEPTH > 1) ? $clog2(RETIRED_DEPTH) : 1;
    localparam int FW = $clog2(RETIRED_DEPTH + 1);

    // configuration
    logic [3:0]  r_cfg_tc;
    logic [4:0]  r_cfg_sc;
    logic [15:0] r_cfg_ep;
    logic [15:0] r_cfg_emp;
    logic        r_cfg_col;

    // sequencer state
    t_state          r_state, n_state;
    logic [63:0]     r_era, n_era;
    logic [TW-1:0]   r_tid, n_tid;
    logic [1:0]      r_op, n_op;
    t_kind           r_kind, n_kind;
    logic [63:0]     r_alloc [THREADS];
    logic [63:0]     n_alloc [THREADS];
    logic [63:0]     r_retire [THREADS];
    logic [63:0]     n_retire [THREADS];
    logic [FW-1:0]   r_fill [THREADS];
    logic [FW-1:0]   n_fill [THREADS];
    logic            r_keep [RETIRED_DEPTH];
    logic            n_keep [RETIRED_DEPTH];
    logic [FW-1:0]   r_e, n_e;
    logic [FW-1:0]   r_w, n_w;
    logic [FW-1:0]   r_sfill, n_sfill;
    logic [TW-1:0]   r_i, n_i;
    logic [SW-1:0]   r_j, n_j;
    logic            r_out_valid, n_out_valid;
    t_res            r_out, n_out;

    // combinational helpers
    logic [3:0]        eff_t;
    logic [4:0]        eff_s;
    logic [15:0]       ep_eff;
    logic [15:0]       emp_eff;
    logic [DIV_W-1:0]  per;
    logic              div_start;
    logic [63:0]       div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_rem;
    logic              res_we;
    logic [SW-1:0]     res_wslot;
    logic              res_clr;
    logic              res_re;
    logic [63:0]       res_q;
    logic              st_we;
    logic [EW-1:0]     st_wa;
    logic [31:0]       st_wh;
    logic [63:0]       st_wb;
    logic [63:0]       st_wend;
    logic              st_re;
    logic [EW-1:0]     st_ra;
    logic [31:0]       st_qh;
    logic [63:0]       st_qb;
    logic [63:0]       st_qend;
    logic              covered;
    logic              last_res;
    logic              go_next;
    logic [TW-1:0]     in_tid;

    // retired store memories
    logic [31:0] st_handle [THREADS][RETIRED_DEPTH];
    logic [63:0] st_birth  [THREADS][RETIRED_DEPTH];
    logic [63:0] st_end    [THREADS][RETIRED_DEPTH];

    // saturate thread and slot counts, force zero periods to one
    always_comb begin
        if (r_cfg_tc == 4'd0) begin
            eff_t = 4'd1;
        end else if (int'(r_cfg_tc) > THREADS) begin
            eff_t = 4'(THREADS);
        end else begin
            eff_t = r_cfg_tc;
        end
        if (r_cfg_sc == 5'd0) begin
            eff_s = 5'd1;
        end else if (int'(r_cfg_sc) > SLOTS) begin
            eff_s = 5'(SLOTS);
        end else begin
            eff_s = r_cfg_sc;
        end
        ep_eff  = (r_cfg_ep == 16'd0) ? 16'd1 : r_cfg_ep;
        emp_eff = (r_cfg_emp == 16'd0) ? 16'd1 : r_cfg_emp;
        per     = DIV_W'(ep_eff) * DIV_W'(eff_t);
    end

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tc  <= 4'd8;
            r_cfg_sc  <= 5'd16;
            r_cfg_ep  <= 16'd150;
            r_cfg_emp <= 16'd30;
            r_cfg_col <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THREAD_COUNT:   r_cfg_tc  <= i_cfg_data[3:0];
                CFG_SLOTS_IN_USE:   r_cfg_sc  <= i_cfg_data[4:0];
                CFG_EPOCH_PERIOD:   r_cfg_ep  <= i_cfg_data;
                CFG_EMPTY_PERIOD:   r_cfg_emp <= i_cfg_data;
                CFG_COLLECT_ENABLE: r_cfg_col <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    her_divmod u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    her_resv #(
        .THREADS (THREADS),
        .SLOTS   (SLOTS)
    ) u_resv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (res_we),
        .i_wtid    (in_tid),
        .i_wslot   (res_wslot),
        .i_wdata   (r_era),
        .i_clr     (res_clr),
        .i_clr_tid (in_tid),
        .i_clr_cnt (eff_s),
        .i_re      (res_re),
        .i_rtid    (r_i),
        .i_rslot   (r_j),
        .o_rdata   (res_q)
    );

    // retired store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_handle[n_tid][st_wa] <= st_wh;
            st_birth[n_tid][st_wa]  <= st_wb;
            st_end[n_tid][st_wa]    <= st_wend;
        end
        if (st_re) begin
            st_qh   <= st_handle[r_tid][st_ra];
            st_qb   <= st_birth[r_tid][st_ra];
            st_qend <= st_end[r_tid][st_ra];
        end
    end

    // compare one reservation against the entry under scan
    always_comb begin
        covered  = (res_q != 64'd0) && (res_q >= st_qb) && (res_q <= st_qend);
        last_res = ((int'(r_j) + 1) >= int'(eff_s)) && ((int'(r_i) + 1) >= int'(eff_t));
        in_tid   = TW'(i_cmd.thread_id);
    end

    // next state and outputs of the sequencer
    always_comb begin
        n_state     = r_state;
        n_era       = r_era;
        n_tid       = r_tid;
        n_op        = r_op;
        n_kind      = r_kind;
        n_alloc     = r_alloc;
        n_retire    = r_retire;
        n_fill      = r_fill;
        n_keep      = r_keep;
        n_e         = r_e;
        n_w         = r_w;
        n_sfill     = r_sfill;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = 1'b0;
        n_out       = r_out;
        div_start    = 1'b0;
        div_dividend = 64'd0;
        div_divisor  = per;
        res_we      = 1'b0;
        res_wslot   = SW'(i_cmd.slot_id);
        res_clr     = 1'b0;
        res_re      = 1'b0;
        st_we       = 1'b0;
        st_wa       = EW'(r_w);
        st_wh       = st_qh;
        st_wb       = st_qb;
        st_wend     = st_qend;
        st_re       = 1'b0;
        st_ra       = r_e[EW-1:0];
        go_next     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_tid  = in_tid;
                    n_op   = i_cmd.command;
                    n_kind = KIND_DONE;
                    n_out  = '{result_kind: KIND_DONE, era: r_era,
                               freed_handle: 32'd0, last: 1'b1};
                    if ({1'b0, i_cmd.thread_id} >= eff_t) begin
                        n_out_valid = 1'b1;
                    end else begin
                        unique case (t_cmd'(i_cmd.command))
                            CMD_ALLOC: begin
                                n_alloc[in_tid] = r_alloc[in_tid] + 64'd1;
                                div_start       = 1'b1;
                                div_dividend    = r_alloc[in_tid] + 64'd1;
                                div_divisor     = per;
                                n_state         = ST_DIV;
                            end
                            CMD_ACQUIRE: begin
                                res_we      = ({1'b0, i_cmd.slot_id} < eff_s);
                                n_out_valid = 1'b1;
                            end
                            CMD_END_OP: begin
                                res_clr     = 1'b1;
                                n_out_valid = 1'b1;
                            end
                            default: begin
                                if (i_cmd.object_handle == 32'd0) begin
                                    n_out.result_kind = KIND_NULL;
                                    n_out_valid       = 1'b1;
                                end else begin
                                    // push the object unless the store is full
                                    if (int'(r_fill[in_tid]) >= RETIRED_DEPTH) begin
                                        n_kind = KIND_FULL;
                                    end else begin
                                        st_we  = 1'b1;
                                        st_wa  = EW'(r_fill[in_tid]);
                                        st_wh  = i_cmd.object_handle;
                                        st_wb  = i_cmd.birth_era;
                                        st_wend = r_era;
                                        n_fill[in_tid] = r_fill[in_tid] + FW'(1);
                                    end
                                    if (r_cfg_col) begin
                                        div_start    = 1'b1;
                                        div_dividend = r_retire[in_tid];
                                        div_divisor  = DIV_W'(emp_eff);
                                        n_state      = ST_DIV;
                                    end else begin
                                        n_retire[in_tid] = r_retire[in_tid] + 64'd1;
                                        n_state          = ST_FINAL;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (t_cmd'(r_op) == CMD_ALLOC) begin
                        n_era       = r_era + ((div_rem == '0) ? 64'd1 : 64'd0);
                        n_out       = '{result_kind: KIND_DONE, era: n_era,
                                       freed_handle: 32'd0, last: 1'b1};
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_retire[r_tid] = r_retire[r_tid] + 64'd1;
                        if (div_rem != '0) begin
                            n_state = ST_FINAL;
                        end else begin
                            // start the scan at the newest entry
                            n_sfill = r_fill[r_tid];
                            n_w     = '0;
                            if (r_fill[r_tid] == '0) begin
                                n_e     = '0;
                                n_state = ST_CSEL;
                            end else begin
                                n_e     = r_fill[r_tid] - FW'(1);
                                n_state = ST_ERD;
                            end
                        end
                    end
                end
            end
            ST_ERD: begin
                st_re   = 1'b1;
                n_i     = '0;
                n_j     = '0;
                n_state = ST_RRD;
            end
            ST_RRD: begin
                res_re  = 1'b1;
                n_state = ST_RCMP;
            end
            ST_RCMP: begin
                if (covered) begin
                    n_keep[r_e[EW-1:0]] = 1'b1;
                    go_next             = 1'b1;
                end else if (last_res) begin
                    // no reservation covers it: reclaim
                    n_keep[r_e[EW-1:0]] = 1'b0;
                    n_out = '{result_kind: KIND_FREED, era: r_era,
                              freed_handle: st_qh, last: 1'b0};
                    n_out_valid = 1'b1;
                    go_next     = 1'b1;
                end else begin
                    if ((int'(r_j) + 1) >= int'(eff_s)) begin
                        n_j = '0;
                        n_i = r_i + TW'(1);
                    end else begin
                        n_j = r_j + SW'(1);
                    end
                    n_state = ST_RRD;
                end
                if (go_next) begin
                    if (r_e == '0) begin
                        n_state = ST_CSEL;
                    end else begin
                        n_e     = r_e - FW'(1);
                        n_state = ST_ERD;
                    end
                end
            end
            ST_CSEL: begin
                // compact kept entries toward the bottom, oldest first
                if (r_e == r_sfill) begin
                    n_fill[r_tid] = r_w;
                    n_state       = ST_FINAL;
                end else if (r_keep[r_e[EW-1:0]]) begin
                    st_re   = 1'b1;
                    n_state = ST_CWR;
                end else begin
                    n_e = r_e + FW'(1);
                end
            end
            ST_CWR: begin
                st_we   = 1'b1;
                st_wa   = EW'(r_w);
                n_w     = r_w + FW'(1);
                n_e     = r_e + FW'(1);
                n_state = ST_CSEL;
            end
            ST_FINAL: begin
                n_out = '{result_kind: r_kind, era: r_era,
                          freed_handle: 32'd0, last: 1'b1};
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_era       <= 64'd1;
            r_out_valid <= 1'b0;
            r_tid       <= '0;
            r_e         <= '0;
            r_sfill     <= '0;
            for (int t = 0; t < THREADS; t++) begin
                r_alloc[t]  <= 64'd0;
                r_retire[t] <= 64'd0;
                r_fill[t]   <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_era       <= n_era;
            r_out_valid <= n_out_valid;
            r_tid       <= n_tid;
            r_e         <= n_e;
            r_sfill     <= n_sfill;
            r_alloc     <= n_alloc;
            r_retire    <= n_retire;
            r_fill      <= n_fill;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_kind <= n_kind;
        r_keep <= n_keep;
        r_w    <= n_w;
        r_i    <= n_i;
        r_j    <= n_j;
        r_out  <= n_out;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    `HER_ASSERT_NXT(a_cmd_answers, start && !busy, o_res_valid || busy)
    `HER_ASSERT_IMP(a_last_idle, o_res_valid && o_res.last, r_state == ST_IDLE)
    `HER_ASSERT_IMP(a_scan_range, r_state == ST_RCMP, r_e < r_sfill)
    `HER_ASSERT_IMP(a_freed_mid, o_res_valid && (o_res.result_kind == KIND_FREED), !o_res.last)

endmodule
`default_nettype wire
